// ===== src/bstk_pkg.sv =====
// Shared constants for the bounded stack with ordered insert.
package bstk_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int DATA_BITS_DEF = 32;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

endpackage

// ===== src/bounded_stack_with_sorted_insert.sv =====
// Bounded stack with ordered insert, held in one synchronous memory.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  request | in        | i_in_valid / o_in_stall    | i_op, i_value
//  result  | out       | o_out_valid / i_out_stall  | o_top_value, o_not_empty,
//          |           |                            | o_entry_count, o_status
//
// Push, clear and any overflow or underflow need no memory read; a pop that
// leaves entries makes one memory read for the new top. An ordered insert
// that skips k entries makes one memory read and one write per entry
// shifted, over the single read port. Reset is synchronous and empties the
// stack at once; the memory needs no clearing pass. A stalled result sits in
// the output register while the next request is taken and worked on.
module bounded_stack_with_sorted_insert #(
    parameter int DEPTH     = bstk_pkg::DEPTH_DEF,
    parameter int DATA_BITS = bstk_pkg::DATA_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int IW       = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_op,
    input  logic [DATA_BITS-1:0] i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_BITS-1:0] o_top_value,
    output logic                 o_not_empty,
    output logic [CW-1:0]        o_entry_count,
    output logic [1:0]           o_status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POPRD = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_fill, n_fill;
    logic [DATA_BITS-1:0] r_top, n_top;
    logic [DATA_BITS-1:0] r_val, n_val;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [1:0]           r_status, n_status;

    logic                 r_ovalid;
    logic [DATA_BITS-1:0] r_otop;
    logic [CW-1:0]        r_ocnt;
    logic [1:0]           r_ostat;

    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_waddr, mem_raddr;
    logic [DATA_BITS-1:0] mem_wdata;

    logic                 accept, full, out_load;
    logic [IW-1:0]        fill_idx;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign full     = (r_fill == CW'(DEPTH));
    assign fill_idx = r_fill[IW-1:0];
    assign out_load = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_top     = r_top;
        n_val     = r_val;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = fill_idx;
        mem_wdata = i_value;
        mem_re    = 1'b0;
        mem_raddr = fill_idx - IW'(2);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = bstk_pkg::ST_OK;
                    n_val    = i_value;
                    n_state  = S_DONE;
                    unique case (i_op)
                        bstk_pkg::OP_PUSH, bstk_pkg::OP_INSERT: begin
                            if (full) begin
                                n_status = bstk_pkg::ST_OVER;
                            end else if (i_op == bstk_pkg::OP_PUSH || r_fill == '0 ||
                                         !($signed(r_top) < $signed(i_value))) begin
                                mem_we = 1'b1;
                                n_fill = r_fill + CW'(1);
                                n_top  = i_value;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = r_top;
                                n_fill    = r_fill + CW'(1);
                                n_idx     = fill_idx - IW'(1);
                                n_pend    = (r_fill != CW'(1));
                                mem_re    = (r_fill != CW'(1));
                                n_state   = S_WALK;
                            end
                        end
                        bstk_pkg::OP_POP: begin
                            if (r_fill == '0) begin
                                n_status = bstk_pkg::ST_UNDER;
                            end else begin
                                n_fill = r_fill - CW'(1);
                                if (r_fill != CW'(1)) begin
                                    mem_re  = 1'b1;
                                    n_state = S_POPRD;
                                end
                            end
                        end
                        bstk_pkg::OP_CLEAR: begin
                            n_fill = '0;
                        end
                    endcase
                end
            end
            S_POPRD: begin
                n_top   = r_rdata;
                n_state = S_DONE;
            end
            S_WALK: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_val;
                mem_raddr = r_idx - IW'(2);
                if (r_pend && ($signed(r_rdata) < $signed(r_val))) begin
                    mem_wdata = r_rdata;
                    n_idx     = r_idx - IW'(1);
                    n_pend    = (r_idx != IW'(1));
                    mem_re    = (r_idx != IW'(1));
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_pend   <= n_pend;
        r_status <= n_status;
        if (out_load) begin
            r_otop  <= (r_fill != '0) ? r_top : '0;
            r_ocnt  <= r_fill;
            r_ostat <= r_status;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_top_value   = r_otop;
    assign o_entry_count = r_ocnt;
    assign o_not_empty   = (r_ocnt != '0);
    assign o_status      = r_ostat;

endmodule

// ===== src/bstk_chk.sv =====
// Port-level checker for the bounded stack, with its bind statement.
module bstk_chk #(
    parameter int DEPTH     = bstk_pkg::DEPTH_DEF,
    parameter int DATA_BITS = bstk_pkg::DATA_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [DATA_BITS-1:0] o_top_value,
    input logic                 o_not_empty,
    input logic [CW-1:0]        o_entry_count,
    input logic [1:0]           o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_top_value) &&
        $stable(o_entry_count) && $stable(o_status))
        else $error("stalled result changed");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_not_empty |-> o_top_value == '0)
        else $error("empty stack shows a nonzero top");

    a_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bstk_pkg::ST_UNDER |-> o_entry_count == '0)
        else $error("underflow on a stack that holds entries");

    a_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bstk_pkg::ST_OVER |-> o_entry_count == CW'(DEPTH))
        else $error("overflow on a stack that is not full");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CW'(DEPTH) && o_status != 2'd3)
        else $error("count or status out of range");

endmodule

bind bounded_stack_with_sorted_insert bstk_chk #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
) u_bstk_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_top_value   (o_top_value),
    .o_not_empty   (o_not_empty),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the bounded stack with ordered insert.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic signed [31:0] top_value;
        logic               not_empty;
        logic [8:0]         entry_count;
        logic [1:0]         status;
    } t_stack_result;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [1:0]          i_op        = bstk_pkg::OP_PUSH;
    logic signed [31:0]  i_value     = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic signed [31:0]  o_top_value;
    logic                o_not_empty;
    logic [8:0]          o_entry_count;
    logic [1:0]          o_status;

    logic signed [31:0]  shadow_stack [bstk_pkg::DEPTH_DEF];
    int unsigned         shadow_fill = 0;
    t_stack_result       pending_results [$];
    int                  error_count = 0;
    int                  sender_idle_pct = 0;
    int                  stall_pct = 0;

    bounded_stack_with_sorted_insert u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_top_value   (o_top_value),
        .o_not_empty   (o_not_empty),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void predict_request(input logic [1:0] op,
                                            input logic signed [31:0] value);
        t_stack_result want;
        int unsigned   pos;
        want.status = bstk_pkg::ST_OK;
        case (op)
            bstk_pkg::OP_PUSH, bstk_pkg::OP_INSERT: begin
                if (shadow_fill >= bstk_pkg::DEPTH_DEF) begin
                    want.status = bstk_pkg::ST_OVER;
                end else if (op == bstk_pkg::OP_PUSH) begin
                    shadow_stack[shadow_fill] = value;
                    shadow_fill++;
                end else begin
                    pos = shadow_fill;
                    while (pos > 0 && shadow_stack[pos-1] < value) pos--;
                    for (int unsigned k = shadow_fill; k > pos; k--)
                        shadow_stack[k] = shadow_stack[k-1];
                    shadow_stack[pos] = value;
                    shadow_fill++;
                end
            end
            bstk_pkg::OP_POP: begin
                if (shadow_fill == 0) want.status = bstk_pkg::ST_UNDER;
                else shadow_fill--;
            end
            default: begin
                shadow_fill = 0;
            end
        endcase
        want.top_value   = (shadow_fill > 0) ? shadow_stack[shadow_fill-1] : '0;
        want.not_empty   = (shadow_fill != 0);
        want.entry_count = shadow_fill[8:0];
        pending_results.push_back(want);
    endfunction

    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result top_value %0d entry_count %0d status %0d",
                         $time, o_top_value, o_entry_count, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top_value) begin
                    $display("%0t: top_value expected %0d actual %0d",
                             $time, want.top_value, o_top_value);
                    error_count++;
                end
                if (o_not_empty !== want.not_empty) begin
                    $display("%0t: not_empty expected %0b actual %0b",
                             $time, want.not_empty, o_not_empty);
                    error_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, o_entry_count);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic signed [31:0] value);
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(op, value);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $signed($urandom_range(0, 16)) - 8;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic test_empty_stack_cases();
        send_request(bstk_pkg::OP_POP, 32'sd5);
        send_request(bstk_pkg::OP_CLEAR, -32'sd1);
        send_request(bstk_pkg::OP_INSERT, 32'sd42);
        send_request(bstk_pkg::OP_POP, 32'sd0);
        send_request(bstk_pkg::OP_POP, 32'sd0);
        send_request(bstk_pkg::OP_PUSH, 32'sd0);
        send_request(bstk_pkg::OP_CLEAR, 32'sd0);
        drain_results();
    endtask

    task automatic test_extremes_and_order();
        send_request(bstk_pkg::OP_PUSH, 32'sh8000_0000);
        send_request(bstk_pkg::OP_PUSH, 32'sh7fff_ffff);
        send_request(bstk_pkg::OP_PUSH, 32'sd0);
        send_request(bstk_pkg::OP_PUSH, -32'sd1);
        send_request(bstk_pkg::OP_INSERT, -32'sd1);
        send_request(bstk_pkg::OP_INSERT, -32'sd5);
        send_request(bstk_pkg::OP_INSERT, 32'sd3);
        send_request(bstk_pkg::OP_INSERT, 32'sh7fff_ffff);
        send_request(bstk_pkg::OP_INSERT, 32'sh8000_0000);
        send_request(bstk_pkg::OP_POP, 32'sh7fff_ffff);
        send_request(bstk_pkg::OP_POP, 32'sd0);
        send_request(bstk_pkg::OP_INSERT, 32'sd0);
        send_request(bstk_pkg::OP_POP, 32'sd0);
        send_request(bstk_pkg::OP_CLEAR, 32'sh7fff_ffff);
        drain_results();
    endtask

    task automatic test_full_stack();
        send_request(bstk_pkg::OP_CLEAR, 32'sd0);
        for (int n = 0; n < bstk_pkg::DEPTH_DEF - 1; n++) begin
            send_request(bstk_pkg::OP_PUSH, $signed($urandom));
        end
        drain_results();
        send_request(bstk_pkg::OP_INSERT, 32'sh7fff_ffff);
        send_request(bstk_pkg::OP_PUSH, 32'sd7);
        send_request(bstk_pkg::OP_INSERT, 32'sh8000_0000);
        send_request(bstk_pkg::OP_POP, 32'sd0);
        send_request(bstk_pkg::OP_INSERT, 32'sh8000_0000);
        send_request(bstk_pkg::OP_INSERT, 32'sd1);
        send_request(bstk_pkg::OP_CLEAR, 32'sd0);
        drain_results();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_level, input int count);
        int          pick;
        logic [1:0]  op;
        sender_idle_pct = idle_pct;
        stall_pct       = stall_level;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) op = bstk_pkg::OP_CLEAR;
            else if (pick < ((shadow_fill > 12) ? 60 : 30)) op = bstk_pkg::OP_POP;
            else if (pick < 70) op = bstk_pkg::OP_INSERT;
            else op = bstk_pkg::OP_PUSH;
            send_request(op, pick_value());
        end
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_stack_cases();
        test_extremes_and_order();
        test_random_phase(0, 0, 42);
        test_random_phase(46, 0, 42);
        test_random_phase(0, 46, 42);
        test_random_phase(9, 9, 42);
        test_full_stack();
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
